/* hw/rtl/fpct_pkg.sv */
package fpct_pkg;

    // action codes
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_POINT  = 2'd1;
    localparam logic [1:0] ACT_SPHERE = 2'd2;
    localparam logic [1:0] ACT_CUBE   = 2'd3;

    // coefficient slots
    localparam logic [1:0] COEF_A = 2'd0;
    localparam logic [1:0] COEF_B = 2'd1;
    localparam logic [1:0] COEF_C = 2'd2;
    localparam logic [1:0] COEF_D = 2'd3;

    // visibility codes
    localparam logic [1:0] VIS_OUTSIDE = 2'd0;
    localparam logic [1:0] VIS_PARTIAL = 2'd1;
    localparam logic [1:0] VIS_INSIDE  = 2'd2;

    localparam int NUM_PLANES_DEF  = 6;
    localparam int VALUE_WIDTH_DEF = 32;

    // one queued beat
    typedef struct packed {
        logic [1:0]         action;
        logic [2:0]         plane_index;
        logic [1:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [30:0]        extent;
    } t_item;

endpackage

/* hw/rtl/fpct_front.sv */
module fpct_front #(
    parameter int NUM_PLANES = fpct_pkg::NUM_PLANES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  fpct_pkg::t_item      i_item,
    output logic                 o_q_valid,
    input  logic                 i_q_pop,
    output fpct_pkg::t_item      o_q_item
);

    fpct_pkg::t_item r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            w_keep;
    logic            w_push;
    logic            w_pop;

    // loads to planes that do not exist are dropped here
    assign w_keep  = (i_item.action != fpct_pkg::ACT_LOAD) ||
                     ({2'b00, i_item.plane_index} < 5'(NUM_PLANES));
    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready && w_keep;
    assign w_pop   = i_q_pop && (r_cnt != 2'd0);

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    // two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

/* hw/rtl/fpct_back.sv */
module fpct_back #(
    parameter int NUM_PLANES  = fpct_pkg::NUM_PLANES_DEF,
    parameter int VALUE_WIDTH = fpct_pkg::VALUE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_pop,
    input  fpct_pkg::t_item      i_q_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_visibility,
    output logic signed [31:0]   o_sphere_distance
);

    localparam int PIW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int SW  = (VALUE_WIDTH > 32) ? 32 : ((VALUE_WIDTH < 16) ? 16 : VALUE_WIDTH);
    localparam logic signed [51:0] SAT_MAX = (52'sd1 <<< (SW - 1)) - 52'sd1;
    localparam logic signed [51:0] SAT_MIN = -(52'sd1 <<< (SW - 1));

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ACC  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic signed [31:0]    r_coef [NUM_PLANES][4];
    fpct_pkg::t_item       r_item;
    logic [PIW-1:0]        r_pl;
    logic signed [63:0]    r_pax;
    logic signed [63:0]    r_pby;
    logic signed [63:0]    r_pcz;
    logic signed [63:0]    r_pd;
    logic [65:0]           r_ext;
    logic [1:0]            r_vis;
    logic signed [67:0]    r_last;
    logic                  r_ovalid;
    logic [1:0]            r_ovis;
    logic signed [31:0]    r_odist;

    logic signed [31:0]    w_a;
    logic signed [31:0]    w_b;
    logic signed [31:0]    w_c;
    logic signed [31:0]    w_d;
    logic [31:0]           w_abs_a;
    logic [31:0]           w_abs_b;
    logic [31:0]           w_abs_c;
    logic [33:0]           w_abs_sum;
    logic [64:0]           w_span;
    logic signed [67:0]    w_dist;
    logic signed [67:0]    w_hi;
    logic signed [67:0]    w_lo;
    logic                  w_hi_pos;
    logic                  w_lo_pos;
    logic signed [51:0]    w_shift;
    logic signed [51:0]    w_sat;
    logic                  w_out_free;
    logic [4:0]            w_pidx;

    assign w_a = r_coef[r_pl][fpct_pkg::COEF_A];
    assign w_b = r_coef[r_pl][fpct_pkg::COEF_B];
    assign w_c = r_coef[r_pl][fpct_pkg::COEF_C];
    assign w_d = r_coef[r_pl][fpct_pkg::COEF_D];

    // box span term: size * (|a|+|b|+|c|)
    assign w_abs_a   = w_a[31] ? 32'(-w_a) : 32'(w_a);
    assign w_abs_b   = w_b[31] ? 32'(-w_b) : 32'(w_b);
    assign w_abs_c   = w_c[31] ? 32'(-w_c) : 32'(w_c);
    assign w_abs_sum = 34'(w_abs_a) + 34'(w_abs_b) + 34'(w_abs_c);
    assign w_span    = 65'(w_abs_sum) * 65'(r_item.extent);

    // exact plane distance and the two bounds
    assign w_dist = 68'(r_pax) + 68'(r_pby) + 68'(r_pcz) + 68'(r_pd);
    assign w_hi   = w_dist + $signed({2'b00, r_ext});
    assign w_lo   = w_dist - $signed({2'b00, r_ext});
    assign w_hi_pos = !w_hi[67] && (w_hi != '0);
    assign w_lo_pos = !w_lo[67] && (w_lo != '0);

    // Q32.32 to Q16.16 floor, then saturate
    assign w_shift = 52'(r_last >>> 16);
    assign w_sat   = (w_shift > SAT_MAX) ? SAT_MAX :
                     ((w_shift < SAT_MIN) ? SAT_MIN : w_shift);

    assign w_out_free = !r_ovalid || i_ready;
    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign w_pidx     = {2'b00, i_q_item.plane_index};

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && i_q_item.action != fpct_pkg::ACT_LOAD) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (!w_hi_pos || r_pl == PIW'(NUM_PLANES - 1)) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // coefficient store, written by load beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                for (int k = 0; k < 4; k++) begin
                    r_coef[p][k] <= '0;
                end
            end
        end else if (o_q_pop && i_q_item.action == fpct_pkg::ACT_LOAD) begin
            r_coef[w_pidx[PIW-1:0]][i_q_item.coef_index] <= i_q_item.coef_value;
        end
    end

    // per-plane datapath
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
            r_pl   <= '0;
            r_vis  <= fpct_pkg::VIS_INSIDE;
        end
        if (r_state == ST_MUL) begin
            r_pax <= w_a * r_item.pos_x;
            r_pby <= w_b * r_item.pos_y;
            r_pcz <= w_c * r_item.pos_z;
            r_pd  <= {{16{w_d[31]}}, w_d, 16'b0};
            unique case (r_item.action)
                fpct_pkg::ACT_SPHERE: r_ext <= {19'b0, r_item.extent, 16'b0};
                fpct_pkg::ACT_CUBE:   r_ext <= {1'b0, w_span};
                default:              r_ext <= '0;
            endcase
        end
        if (r_state == ST_ACC) begin
            r_last <= w_hi;
            r_pl   <= r_pl + 1'b1;
            if (!w_hi_pos) begin
                r_vis <= fpct_pkg::VIS_OUTSIDE;
            end else if (!w_lo_pos) begin
                r_vis <= fpct_pkg::VIS_PARTIAL;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            r_ovis <= r_vis;
            if (r_item.action == fpct_pkg::ACT_SPHERE && r_vis != fpct_pkg::VIS_OUTSIDE) begin
                r_odist <= w_sat[31:0];
            end else begin
                r_odist <= '0;
            end
        end
    end

    assign o_valid           = r_ovalid;
    assign o_visibility      = r_ovis;
    assign o_sphere_distance = r_odist;

endmodule

/* hw/rtl/frustum_plane_cull_test.sv */
// A load beat writes its coefficient when popped. A test visits the planes in
// order (multiply, then sum and compare) up to the first one it is wholly
// outside. The shared plane unit takes no beat during a test; loads drain at one
// per cycle when idle. A 2-entry queue decouples input.
// Reset (i_rst_n low, synchronous): queue and result empty, planes all zero.
module frustum_plane_cull_test #(
    parameter int NUM_PLANES  = fpct_pkg::NUM_PLANES_DEF,
    parameter int VALUE_WIDTH = fpct_pkg::VALUE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_action,
    input  logic [2:0]          i_plane_index,
    input  logic [1:0]          i_coef_index,
    input  logic signed [31:0]  i_coef_value,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic [30:0]         i_extent,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_visibility,
    output logic signed [31:0]  o_sphere_distance
);

    fpct_pkg::t_item w_in_item;
    fpct_pkg::t_item w_q_item;
    logic            w_q_valid;
    logic            w_q_pop;

    assign w_in_item.action      = i_action;
    assign w_in_item.plane_index = i_plane_index;
    assign w_in_item.coef_index  = i_coef_index;
    assign w_in_item.coef_value  = i_coef_value;
    assign w_in_item.pos_x       = i_pos_x;
    assign w_in_item.pos_y       = i_pos_y;
    assign w_in_item.pos_z       = i_pos_z;
    assign w_in_item.extent      = i_extent;

    fpct_front #(
        .NUM_PLANES (NUM_PLANES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (w_in_item),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_item  (w_q_item)
    );

    fpct_back #(
        .NUM_PLANES  (NUM_PLANES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (w_q_valid),
        .o_q_pop           (w_q_pop),
        .i_q_item          (w_q_item),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_visibility      (o_visibility),
        .o_sphere_distance (o_sphere_distance)
    );

endmodule
